>>> rtl/core/pmet_pkg.sv
// shared types, codes and widths for the per-material energy tally
package pmet_pkg;

    // default and largest material count
    localparam int DEF_NUM_MATERIALS = 16;
    localparam int MAX_MATERIALS     = 64;

    // transaction field widths
    localparam int ACTION_W = 3;
    localparam int MAT_W    = 7;
    localparam int ENERGY_W = 32;
    localparam int WEIGHT_W = 18;

    // arithmetic widths
    localparam int FRAC_DROP = 16;
    localparam int PROD_W    = ENERGY_W + WEIGHT_W;
    localparam int AMT_W     = PROD_W - FRAC_DROP;
    localparam int ACC_W     = 48;
    localparam int TOT_W     = 64;
    localparam int SQ_W      = 64;

    // slot number carried in a command, wide enough for the largest count
    localparam int SLOT_W = $clog2(MAX_MATERIALS);

    // depth of the command queue between front and back
    localparam int FIFO_DEPTH = 4;

    // action codes on the input channel
    localparam logic [ACTION_W-1:0] ACT_LOCAL_DEPOSIT  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_BEGIN_PARTICLE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SAMPLED        = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_STEP           = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_MOVE_GEOM      = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_END_HISTORY    = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_READ_OUT       = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_CLEAR          = 3'd7;

    // command codes in the queue
    localparam logic [1:0] CMD_DEPOSIT     = 2'd0;
    localparam logic [1:0] CMD_END_HISTORY = 2'd1;
    localparam logic [1:0] CMD_READ_OUT    = 2'd2;
    localparam logic [1:0] CMD_CLEAR       = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot;
        logic              subtract;
        logic [AMT_W-1:0]  amount;
    } t_cmd;

endpackage

>>> rtl/core/per_material_energy_tally.sv
// top level of the per-material energy tally
//
// keeps, for each material, a signed per-history accumulator, a signed running
// total and an unsigned running sum of squares, all saturating. deposit-type
// transactions add floor(energy * weight / 2^16) (q.8 ev) to the addressed
// material's accumulator, begin-particle subtracts it; material 0 and numbers
// above NUM_MATERIALS are dropped in the front end. end-history folds every
// accumulator into its total and its squared magnitude (whole ev^2) into the sum
// of squares, then zeroes it. read-out sends one result transaction per
// material in order, with o_last on the final one. clear zeroes everything
// through per-entry valid bits. the front end registers the transaction and
// forms the product, then queues a command in a four-deep queue, so input is
// accepted while the back end works, until the queue fills. the back end
// handles a deposit as an accumulator memory read, then a saturating write,
// an end-history as a walk over all materials (each material goes through the
// single shared 24x24 multiplier three times), and a read-out as a walk that
// reads each material's row and sends it once the output side is free;
// results leave through an output register. no clearing pass is needed after
// reset.
module per_material_energy_tally
    import pmet_pkg::*;
#(
    parameter int NUM_MATERIALS = DEF_NUM_MATERIALS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input transaction channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [ACTION_W-1:0]     i_action,
    input  logic [MAT_W-1:0]        i_material,
    input  logic [ENERGY_W-1:0]     i_energy,
    input  logic [WEIGHT_W-1:0]     i_weight,
    // result transaction channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [MAT_W-1:0]        o_material_index,
    output logic signed [TOT_W-1:0] o_total,
    output logic [SQ_W-1:0]         o_total_squares,
    output logic                    o_last
);

    // front end to queue
    logic push;
    t_cmd push_cmd;
    logic full;

    // queue to back end
    logic pop;
    t_cmd head_cmd;
    logic empty;

    // classifies transactions and computes the weighted energy
    pmet_front #(
        .NUM_MATERIALS (NUM_MATERIALS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_action   (i_action),
        .i_material (i_material),
        .i_energy   (i_energy),
        .i_weight   (i_weight),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .i_full     (full)
    );

    // decouples acceptance from the long end-history and read-out walks
    pmet_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty)
    );

    // owns the material stores and the output register
    pmet_back #(
        .NUM_MATERIALS (NUM_MATERIALS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (empty),
        .i_cmd            (head_cmd),
        .o_pop            (pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_material_index (o_material_index),
        .o_total          (o_total),
        .o_total_squares  (o_total_squares),
        .o_last           (o_last)
    );

endmodule

>>> rtl/core/pmet_front.sv
// front end: accepts transactions, forms the weighted energy and classifies them
module pmet_front
    import pmet_pkg::*;
#(
    parameter int NUM_MATERIALS = DEF_NUM_MATERIALS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [MAT_W-1:0]    i_material,
    input  logic [ENERGY_W-1:0] i_energy,
    input  logic [WEIGHT_W-1:0] i_weight,
    output logic                o_push,
    output t_cmd                o_cmd,
    input  logic                i_full
);

    logic                r_stg_vld;
    logic [ACTION_W-1:0] r_act;
    logic [MAT_W-1:0]    r_mat;
    logic [ENERGY_W-1:0] r_energy;
    logic [WEIGHT_W-1:0] r_weight;

    logic              mat_ok;
    logic [MAT_W-1:0]  mat_m1;
    logic [PROD_W-1:0] product;
    logic              keep;
    logic              stg_done;

    assign mat_ok  = (r_mat != '0) && (r_mat <= MAT_W'(NUM_MATERIALS));
    assign mat_m1  = r_mat - MAT_W'(1);
    assign product = PROD_W'(r_energy) * PROD_W'(r_weight);

    always_comb begin
        keep           = 1'b1;
        o_cmd.op       = CMD_DEPOSIT;
        o_cmd.slot     = mat_m1[SLOT_W-1:0];
        o_cmd.subtract = 1'b0;
        o_cmd.amount   = product[PROD_W-1:FRAC_DROP];
        unique case (r_act) inside
            ACT_LOCAL_DEPOSIT, ACT_SAMPLED, ACT_STEP, ACT_MOVE_GEOM: begin
                keep = mat_ok;
            end
            ACT_BEGIN_PARTICLE: begin
                keep           = mat_ok;
                o_cmd.subtract = 1'b1;
            end
            ACT_END_HISTORY: begin
                o_cmd.op = CMD_END_HISTORY;
            end
            ACT_READ_OUT: begin
                o_cmd.op = CMD_READ_OUT;
            end
            default: begin
                o_cmd.op = CMD_CLEAR;
            end
        endcase
    end

    // void or out-of-range events leave the stage without a command
    assign o_push   = r_stg_vld && keep && !i_full;
    assign stg_done = r_stg_vld && (!keep || !i_full);
    assign o_ready  = !r_stg_vld || stg_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
        end else if (o_ready) begin
            r_stg_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_act    <= i_action;
            r_mat    <= i_material;
            r_energy <= i_energy;
            r_weight <= i_weight;
        end
    end

endmodule

>>> rtl/core/pmet_cmd_fifo.sv
// short command queue between the front end and the execution back end
module pmet_cmd_fifo
    import pmet_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_cmd             r_entry [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/pmet_back.sv
// back end: accumulator updates, end-of-history fold, read-out and clear
module pmet_back
    import pmet_pkg::*;
#(
    parameter int NUM_MATERIALS = DEF_NUM_MATERIALS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_empty,
    input  t_cmd                    i_cmd,
    output logic                    o_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [MAT_W-1:0]        o_material_index,
    output logic signed [TOT_W-1:0] o_total,
    output logic [SQ_W-1:0]         o_total_squares,
    output logic                    o_last
);

    localparam int IDX_W   = (NUM_MATERIALS > 1) ? $clog2(NUM_MATERIALS) : 1;
    localparam int DEP_W   = ACC_W + 2;
    localparam int SQ_FR   = 16;
    localparam int SQ_LIM  = 40;
    localparam int MUL_W   = SQ_LIM - SQ_FR;
    localparam int MPROD_W = 2 * MUL_W;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MATERIALS - 1);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DEP_WR  = 4'd1;
    localparam logic [3:0] ST_EH_RD   = 4'd2;
    localparam logic [3:0] ST_EH_MAG  = 4'd3;
    localparam logic [3:0] ST_EH_M0   = 4'd4;
    localparam logic [3:0] ST_EH_M1   = 4'd5;
    localparam logic [3:0] ST_EH_M2   = 4'd6;
    localparam logic [3:0] ST_EH_M3   = 4'd7;
    localparam logic [3:0] ST_EH_WB   = 4'd8;
    localparam logic [3:0] ST_RO_RD   = 4'd9;
    localparam logic [3:0] ST_RO_DATA = 4'd10;

    // storage
    logic [ACC_W-1:0] r_acc_mem [NUM_MATERIALS];
    logic [TOT_W-1:0] r_tot_mem [NUM_MATERIALS];
    logic [SQ_W-1:0]  r_sq_mem  [NUM_MATERIALS];
    logic [NUM_MATERIALS-1:0] r_acc_vld;
    logic [NUM_MATERIALS-1:0] r_row_vld;

    // control
    logic [3:0]       r_state, n_state;
    logic [IDX_W-1:0] r_walk, n_walk;

    // payload
    logic [IDX_W-1:0]   r_slot;
    logic               r_sub;
    logic [AMT_W-1:0]   r_amount;
    logic [ACC_W-1:0]   r_acc_rd;
    logic [TOT_W-1:0]   r_tot_rd;
    logic [SQ_W-1:0]    r_sq_rd;
    logic               r_acc_rvld;
    logic               r_row_rvld;
    logic [ACC_W-1:0]   r_a;
    logic [ACC_W-1:0]   r_mag;
    logic [MPROD_W-1:0] r_prod;
    logic [SQ_W-1:0]    r_sqr;

    logic               r_out_vld;
    logic [MAT_W-1:0]   r_out_idx;
    logic [TOT_W-1:0]   r_out_tot;
    logic [SQ_W-1:0]    r_out_sq;
    logic               r_out_last;

    // memory ports
    logic             acc_rd_en, acc_wr_en, row_rd_en, row_wr_en;
    logic [IDX_W-1:0] acc_rd_addr, row_addr;
    logic [ACC_W-1:0] acc_wr_data;
    logic [TOT_W-1:0] tot_wr_data;
    logic [SQ_W-1:0]  sq_wr_data;

    // datapath
    logic [ACC_W-1:0]   acc_cur;
    logic [DEP_W-1:0]   acc_ext, amt_ext, dep_sum;
    logic [2:0]         dep_top;
    logic [ACC_W-1:0]   a_cur;
    logic [MUL_W-1:0]   mul_a, mul_b;
    logic [MUL_W-1:0]   sq_hi, sq_lo;
    logic [TOT_W-1:0]   tot_cur;
    logic [TOT_W:0]     tot_sum;
    logic [SQ_W-1:0]    sq_cur, sq_term;
    logic [SQ_W:0]      sq_sum;
    logic               out_free;
    logic               clear_all;

    assign out_free = !r_out_vld || i_ready;

    // saturating accumulator update
    assign acc_cur = r_acc_rvld ? r_acc_rd : '0;
    assign acc_ext = {{(DEP_W - ACC_W){acc_cur[ACC_W-1]}}, acc_cur};
    assign amt_ext = {{(DEP_W - AMT_W){1'b0}}, r_amount};
    assign dep_sum = r_sub ? (acc_ext - amt_ext) : (acc_ext + amt_ext);
    assign dep_top = dep_sum[DEP_W-1:ACC_W-1];

    always_comb begin
        if ((&dep_top) || !(|dep_top)) begin
            acc_wr_data = dep_sum[ACC_W-1:0];
        end else if (dep_sum[DEP_W-1]) begin
            acc_wr_data = {1'b1, {(ACC_W - 1){1'b0}}};
        end else begin
            acc_wr_data = {1'b0, {(ACC_W - 1){1'b1}}};
        end
    end

    // end-of-history fold
    assign a_cur = r_acc_rvld ? r_acc_rd : '0;
    assign sq_hi = r_mag[SQ_LIM-1:SQ_FR];
    assign sq_lo = {{(MUL_W - SQ_FR){1'b0}}, r_mag[SQ_FR-1:0]};

    always_comb begin
        mul_a = sq_lo;
        mul_b = sq_lo;
        if (r_state == ST_EH_M0) begin
            mul_a = sq_hi;
            mul_b = sq_hi;
        end else if (r_state == ST_EH_M1) begin
            mul_a = sq_hi;
            mul_b = sq_lo;
        end
    end

    assign tot_cur = r_row_rvld ? r_tot_rd : '0;
    assign tot_sum = {tot_cur[TOT_W-1], tot_cur}
                   + {{(TOT_W - ACC_W + 1){r_a[ACC_W-1]}}, r_a};

    always_comb begin
        if (tot_sum[TOT_W] == tot_sum[TOT_W-1]) begin
            tot_wr_data = tot_sum[TOT_W-1:0];
        end else if (tot_sum[TOT_W]) begin
            tot_wr_data = {1'b1, {(TOT_W - 1){1'b0}}};
        end else begin
            tot_wr_data = {1'b0, {(TOT_W - 1){1'b1}}};
        end
    end

    // squares of magnitudes at or above 2^40 overflow 64 bits
    assign sq_cur     = r_row_rvld ? r_sq_rd : '0;
    assign sq_term    = (|r_mag[ACC_W-1:SQ_LIM]) ? '1 : r_sqr;
    assign sq_sum     = {1'b0, sq_cur} + {1'b0, sq_term};
    assign sq_wr_data = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_walk      = r_walk;
        o_pop       = 1'b0;
        clear_all   = 1'b0;
        acc_rd_en   = 1'b0;
        acc_rd_addr = r_walk;
        acc_wr_en   = 1'b0;
        row_rd_en   = 1'b0;
        row_wr_en   = 1'b0;
        row_addr    = r_walk;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        CMD_DEPOSIT: begin
                            acc_rd_en   = 1'b1;
                            acc_rd_addr = i_cmd.slot[IDX_W-1:0];
                            n_state     = ST_DEP_WR;
                        end
                        CMD_END_HISTORY: begin
                            n_walk  = '0;
                            n_state = ST_EH_RD;
                        end
                        CMD_READ_OUT: begin
                            n_walk  = '0;
                            n_state = ST_RO_RD;
                        end
                        default: begin
                            clear_all = 1'b1;
                        end
                    endcase
                end
            end
            ST_DEP_WR: begin
                acc_wr_en = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_EH_RD: begin
                acc_rd_en = 1'b1;
                row_rd_en = 1'b1;
                n_state   = ST_EH_MAG;
            end
            ST_EH_MAG: n_state = ST_EH_M0;
            ST_EH_M0:  n_state = ST_EH_M1;
            ST_EH_M1:  n_state = ST_EH_M2;
            ST_EH_M2:  n_state = ST_EH_M3;
            ST_EH_M3:  n_state = ST_EH_WB;
            ST_EH_WB: begin
                row_wr_en = 1'b1;
                if (r_walk == LAST_IDX) begin
                    n_state = ST_IDLE;
                end else begin
                    n_walk  = r_walk + IDX_W'(1);
                    n_state = ST_EH_RD;
                end
            end
            ST_RO_RD: begin
                row_rd_en = 1'b1;
                n_state   = ST_RO_DATA;
            end
            ST_RO_DATA: begin
                if (out_free) begin
                    if (r_walk == LAST_IDX) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_walk  = r_walk + IDX_W'(1);
                        n_state = ST_RO_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control registers and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_walk    <= '0;
            r_acc_vld <= '0;
            r_row_vld <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_walk  <= n_walk;
            if (clear_all) begin
                r_acc_vld <= '0;
                r_row_vld <= '0;
            end else if (acc_wr_en) begin
                r_acc_vld[r_slot] <= 1'b1;
            end else if (row_wr_en) begin
                r_acc_vld[r_walk] <= 1'b0;
                r_row_vld[r_walk] <= 1'b1;
            end
            if (r_state == ST_RO_DATA && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (acc_wr_en) begin
            r_acc_mem[r_slot] <= acc_wr_data;
        end
        if (acc_rd_en) begin
            r_acc_rd   <= r_acc_mem[acc_rd_addr];
            r_acc_rvld <= r_acc_vld[acc_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_wr_en) begin
            r_tot_mem[row_addr] <= tot_wr_data;
            r_sq_mem[row_addr]  <= sq_wr_data;
        end
        if (row_rd_en) begin
            r_tot_rd   <= r_tot_mem[row_addr];
            r_sq_rd    <= r_sq_mem[row_addr];
            r_row_rvld <= r_row_vld[row_addr];
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_slot   <= i_cmd.slot[IDX_W-1:0];
            r_sub    <= i_cmd.subtract;
            r_amount <= i_cmd.amount;
        end
        if (r_state == ST_EH_MAG) begin
            r_a   <= a_cur;
            r_mag <= a_cur[ACC_W-1] ? (ACC_W'(0) - a_cur) : a_cur;
        end
        if (r_state == ST_EH_M0 || r_state == ST_EH_M1 || r_state == ST_EH_M2) begin
            r_prod <= MPROD_W'(mul_a) * MPROD_W'(mul_b);
        end
        if (r_state == ST_EH_M1) begin
            r_sqr <= {r_prod, {SQ_FR{1'b0}}};
        end else if (r_state == ST_EH_M2) begin
            r_sqr <= r_sqr + {{(SQ_W - MPROD_W - 1){1'b0}}, r_prod, 1'b0};
        end else if (r_state == ST_EH_M3) begin
            r_sqr <= r_sqr + {{(SQ_W - MPROD_W + SQ_FR){1'b0}}, r_prod[MPROD_W-1:SQ_FR]};
        end
        if (r_state == ST_RO_DATA && out_free) begin
            r_out_idx  <= MAT_W'(r_walk) + MAT_W'(1);
            r_out_tot  <= tot_cur;
            r_out_sq   <= sq_cur;
            r_out_last <= (r_walk == LAST_IDX);
        end
    end

    assign o_valid          = r_out_vld;
    assign o_material_index = r_out_idx;
    assign o_total          = r_out_tot;
    assign o_total_squares  = r_out_sq;
    assign o_last           = r_out_last;

`ifndef ASSERT_OFF
    a_dep_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DEP_WR |=> r_state == ST_IDLE)
        else $error("accumulator update did not return to idle");

    a_mul_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EH_M0 |=> r_state == ST_EH_M1)
        else $error("square partial products out of order");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_last |-> r_out_idx == MAT_W'(NUM_MATERIALS))
        else $error("last flag on wrong material");

    a_fold_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EH_WB && r_walk == LAST_IDX |=> r_state == ST_IDLE)
        else $error("end-of-history walk overran");
`endif

endmodule
